@@ design/fmg_pkg.sv @@
// Shared types and constants for the focus mask grayscale block.
package fmg_pkg;

	// Register indexes on the configuration port.
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_FOCUS_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FOCUS_FIRST = 3'd1;

	localparam int CFG_DATA_W = 48;
	localparam int COUNT_W = 3;
	// cx[15:0], cy[31:16], radius[46:32]
	localparam int CIRCLE_W = 47;

	localparam int FOCUS_SLOTS_DEFAULT = 7;

	// BT.601 luma weights in Q16, summing to 65536.
	localparam logic [14:0] LUMA_WR = 15'd19595;
	localparam logic [15:0] LUMA_WG = 16'd38470;
	localparam logic [12:0] LUMA_WB = 13'd7471;

	typedef struct packed {
		logic [14:0] x;
		logic [14:0] y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  luma;
		logic        hit;
	} fmg_item_t;

	typedef struct packed {
		logic advance;
		logic write;
		logic enable;
	} fmg_ctl_t;

endpackage

@@ design/fmg_luma.sv @@
// Two-stage BT.601 luma unit at the head of the circle chain.
module fmg_luma (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             up_valid,
	input  logic [14:0]      x,
	input  logic [14:0]      y,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	output logic             dn_valid,
	output fmg_pkg::fmg_item_t dn_item
);
	import fmg_pkg::*;

	logic        valid_s1;
	logic        valid_s2;
	logic [22:0] prod_r_s1;
	logic [23:0] prod_g_s1;
	logic [20:0] prod_b_s1;
	fmg_item_t   item_s1;
	fmg_item_t   item_s2;
	fmg_item_t   item_luma;
	logic [23:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Weighted channels, one multiplier each.
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_r_s1     <= 23'(red) * 23'(LUMA_WR);
			prod_g_s1     <= 24'(green) * 24'(LUMA_WG);
			prod_b_s1     <= 21'(blue) * 21'(LUMA_WB);
			item_s1.x     <= x;
			item_s1.y     <= y;
			item_s1.red   <= red;
			item_s1.green <= green;
			item_s1.blue  <= blue;
			item_s1.luma  <= 8'd0;
			item_s1.hit   <= 1'b0;
		end
	end

	assign sum = 24'(prod_r_s1) + prod_g_s1 + 24'(prod_b_s1);

	always_comb begin
		item_luma      = item_s1;
		item_luma.luma = sum[23:16];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= item_luma;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_item  = item_s2;

endmodule

@@ design/fmg_cell.sv @@
// One circle cell: holds one focus circle and tests each passing pixel against it.
module fmg_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fmg_pkg::fmg_ctl_t             ctl,
	input  logic [fmg_pkg::CIRCLE_W-1:0]  circle_data,
	input  logic                          up_valid,
	input  fmg_pkg::fmg_item_t            up_item,
	output logic                          dn_valid,
	output fmg_pkg::fmg_item_t            dn_item
);
	import fmg_pkg::*;

	logic [CIRCLE_W-1:0] circle_q;
	logic signed [17:0]  dx;
	logic signed [17:0]  dy;
	logic [17:0]         dx_neg;
	logic [17:0]         dy_neg;
	logic [15:0]         adx;
	logic [15:0]         ady;
	logic [31:0]         dx_sq;
	logic [31:0]         dy_sq;
	logic [29:0]         r_sq;
	logic                valid_s1;
	logic                valid_s2;
	logic [31:0]         dx_sq_s1;
	logic [31:0]         dy_sq_s1;
	logic [29:0]         r_sq_s1;
	fmg_item_t           item_s1;
	fmg_item_t           item_s2;
	fmg_item_t           item_hit;
	logic [32:0]         dist_sq;
	logic                in_circle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circle_q <= '0;
		end else if (ctl.write) begin
			circle_q <= circle_data;
		end
	end

	// |dx| never exceeds 65535, so 16 bits carry the magnitude.
	assign dx = $signed({3'b000, up_item.x}) - $signed({{2{circle_q[15]}}, circle_q[15:0]});
	assign dy = $signed({3'b000, up_item.y}) - $signed({{2{circle_q[31]}}, circle_q[31:16]});
	assign dx_neg = -dx;
	assign dy_neg = -dy;
	assign adx = dx[17] ? dx_neg[15:0] : dx[15:0];
	assign ady = dy[17] ? dy_neg[15:0] : dy[15:0];
	assign dx_sq = 32'(adx) * 32'(adx);
	assign dy_sq = 32'(ady) * 32'(ady);
	assign r_sq  = 30'(circle_q[46:32]) * 30'(circle_q[46:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (ctl.advance) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign dist_sq   = {1'b0, dx_sq_s1} + {1'b0, dy_sq_s1};
	assign in_circle = ctl.enable && (dist_sq <= {3'b000, r_sq_s1});

	always_comb begin
		item_hit     = item_s1;
		item_hit.hit = item_s1.hit | in_circle;
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			dx_sq_s1 <= dx_sq;
			dy_sq_s1 <= dy_sq;
			r_sq_s1  <= r_sq;
			item_s1  <= up_item;
			item_s2  <= item_hit;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_item  = item_s2;

endmodule

@@ design/focus_mask_grayscale.sv @@
// Top level: luma unit followed by a chain of circle cells, one per focus slot.
// A pixel transaction passes the two luma stages, then both stages of each circle cell.
// Throughput: one pixel per cycle unless stalled; the luma unit has two stages and each
// circle cell two (square, then add and compare), and the whole chain advances together.
// A stalled result holds the chain in place and stalls the pixel side in the same cycle.
// Reset (arst_n low) empties the pipeline and clears focus_count and all circles to zero.
module focus_mask_grayscale #(
	parameter int FOCUS_SLOTS = fmg_pkg::FOCUS_SLOTS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  logic [14:0]                      pixel_x,
	input  logic [14:0]                      pixel_y,
	input  logic [7:0]                       red_in,
	input  logic [7:0]                       green_in,
	input  logic [7:0]                       blue_in,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [7:0]                       red_out,
	output logic [7:0]                       green_out,
	output logic [7:0]                       blue_out,
	output logic                             in_focus,
	input  logic                             cfg_write,
	input  logic [fmg_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [fmg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fmg_pkg::*;

	logic               advance;
	logic [COUNT_W-1:0] focus_count_q;
	logic               chain_valid [FOCUS_SLOTS+1];
	fmg_item_t          chain_item  [FOCUS_SLOTS+1];
	fmg_item_t          last_item;

	// Advance every stage whenever the result register is free or being taken.
	assign advance   = !res_valid || !res_stall;
	assign pix_stall = !advance;

	// Count register; a count above the slot number simply enables every cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focus_count_q <= '0;
		end else if (cfg_write && (cfg_index == REG_FOCUS_COUNT)) begin
			focus_count_q <= cfg_data[COUNT_W-1:0];
		end
	end

	fmg_luma u_luma (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.up_valid (pix_valid),
		.x        (pixel_x),
		.y        (pixel_y),
		.red      (red_in),
		.green    (green_in),
		.blue     (blue_in),
		.dn_valid (chain_valid[0]),
		.dn_item  (chain_item[0])
	);

	// Each cell owns one circle register and ORs its hit into the passing pixel.
	for (genvar i = 0; i < FOCUS_SLOTS; i++) begin : g_cell
		fmg_ctl_t ctl;

		assign ctl.advance = advance;
		assign ctl.write   = cfg_write && (cfg_index == (REG_FOCUS_FIRST + REG_IDX_W'(i)));
		assign ctl.enable  = focus_count_q > COUNT_W'(i);

		fmg_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.circle_data (cfg_data[CIRCLE_W-1:0]),
			.up_valid    (chain_valid[i]),
			.up_item     (chain_item[i]),
			.dn_valid    (chain_valid[i+1]),
			.dn_item     (chain_item[i+1])
		);
	end

	// The last cell's stage register is the result register; drop color outside focus.
	assign last_item = chain_item[FOCUS_SLOTS];
	assign res_valid = chain_valid[FOCUS_SLOTS];
	assign in_focus  = last_item.hit;
	assign red_out   = last_item.hit ? last_item.red   : last_item.luma;
	assign green_out = last_item.hit ? last_item.green : last_item.luma;
	assign blue_out  = last_item.hit ? last_item.blue  : last_item.luma;

`ifndef SYNTHESIS
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !pix_stall)
		else $error("pixel side stalled with an empty result register");

	a_gray_equal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !in_focus |-> (red_out == green_out) && (green_out == blue_out))
		else $error("gray result with unequal channels");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=>
			res_valid && $stable({red_out, green_out, blue_out, in_focus}))
		else $error("stalled result transaction changed");
`endif

endmodule
